>>> hw/rtl/rsl_pkg.sv
`default_nettype none
package rsl_pkg;

    localparam int CENTER_BITS = 14;
    localparam int RADIUS      = 200;
    localparam int RAD_SQ      = RADIUS * RADIUS;
    localparam int AXIS_BITS   = 8;     // |dx|, |dy| below the radius
    localparam int DSQ_BITS    = 16;    // squared distance below the radius squared
    localparam int ROOT_BITS   = 16;
    localparam int RAD_BITS    = 2 * ROOT_BITS;
    localparam int REM_BITS    = ROOT_BITS + 4;
    localparam int SQ_STAGES   = 4;
    localparam int SQ_STEPS    = ROOT_BITS / SQ_STAGES;

    // factor = one - floor((64*d8 + 25) / 50), the division by a reciprocal
    localparam int          NUM_BITS    = ROOT_BITS + 6;
    localparam int          RECIP_SHIFT = 28;
    localparam int          RECIP_BITS  = 23;
    localparam int          PROD_BITS   = NUM_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP_M = RECIP_BITS'((64'd1 << RECIP_SHIFT) / 50 + 1);
    localparam logic [NUM_BITS-1:0]   ROUND_ADD = NUM_BITS'(25);
    localparam int          FACTOR_BITS = 17;
    localparam logic [FACTOR_BITS-1:0] ONE_Q16 = FACTOR_BITS'(65536);

    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;

    typedef enum logic {
        REG_CENTER_X = 1'b0,
        REG_CENTER_Y = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic vld;
        logic zero;     // at or beyond the radius
    } t_ctl;

    typedef struct packed {
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
        logic [RAD_BITS-1:0]  rad;
    } t_sq;

    // a few digit steps of the restoring square root, two radicand bits each
    function automatic t_sq sqrt_steps(input t_sq s_in);
        t_sq                 s;
        logic [REM_BITS-1:0] trial;
        s = s_in;
        for (int k = 0; k < SQ_STEPS; k++) begin
            s.rem = {s.rem[REM_BITS-3:0], s.rad[RAD_BITS-1 -: 2]};
            s.rad = {s.rad[RAD_BITS-3:0], 2'b00};
            trial = {{(REM_BITS-ROOT_BITS-2){1'b0}}, s.root, 2'b01};
            if (s.rem >= trial) begin
                s.rem  = s.rem - trial;
                s.root = {s.root[ROOT_BITS-2:0], 1'b1};
            end else begin
                s.root = {s.root[ROOT_BITS-2:0], 1'b0};
            end
        end
        return s;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rsl_dist.sv
`default_nettype none
module rsl_dist #(
    parameter int COORD_BITS = 12,
    parameter int LUM_BITS   = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire logic [COORD_BITS-1:0]         i_col,
    input  wire logic [COORD_BITS-1:0]         i_row,
    input  wire logic [LUM_BITS-1:0]           i_lum,
    input  wire logic [rsl_pkg::CENTER_BITS-1:0] i_cx,
    input  wire logic [rsl_pkg::CENTER_BITS-1:0] i_cy,
    output rsl_pkg::t_ctl                      o_ctl,
    output logic [rsl_pkg::DSQ_BITS-1:0]       o_dsq,
    output logic [LUM_BITS-1:0]                o_lum
);
    import rsl_pkg::*;

    localparam int DX_W = ((COORD_BITS + 1 > CENTER_BITS) ? COORD_BITS + 1 : CENTER_BITS) + 1;

    logic [DX_W-1:0]      dx, dy, abs_x, abs_y;
    logic [AXIS_BITS-1:0] r_ax, r_ay;
    logic                 r_far, r_vld_a;
    logic [LUM_BITS-1:0]  r_lum_a, r_lum;
    logic [2*AXIS_BITS:0] sum;
    logic [DSQ_BITS-1:0]  r_dsq;
    logic                 r_vld, r_zero;

    // offsets from the center, sign-extended and exact
    assign dx    = {{(DX_W-COORD_BITS){1'b0}}, i_col}
                 - {{(DX_W-CENTER_BITS){i_cx[CENTER_BITS-1]}}, i_cx};
    assign dy    = {{(DX_W-COORD_BITS){1'b0}}, i_row}
                 - {{(DX_W-CENTER_BITS){i_cy[CENTER_BITS-1]}}, i_cy};
    assign abs_x = dx[DX_W-1] ? (~dx + DX_W'(1)) : dx;
    assign abs_y = dy[DX_W-1] ? (~dy + DX_W'(1)) : dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax    <= abs_x[AXIS_BITS-1:0];
            r_ay    <= abs_y[AXIS_BITS-1:0];
            r_far   <= (abs_x >= DX_W'(RADIUS)) || (abs_y >= DX_W'(RADIUS));
            r_lum_a <= i_lum;
        end
    end

    assign sum = (2*AXIS_BITS+1)'(r_ax) * (2*AXIS_BITS+1)'(r_ax)
               + (2*AXIS_BITS+1)'(r_ay) * (2*AXIS_BITS+1)'(r_ay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dsq  <= sum[DSQ_BITS-1:0];
            r_zero <= r_far || (sum >= (2*AXIS_BITS+1)'(RAD_SQ));
            r_lum  <= r_lum_a;
        end
    end

    assign o_ctl = '{vld: r_vld, zero: r_zero};
    assign o_dsq = r_dsq;
    assign o_lum = r_lum;

endmodule
`default_nettype wire

>>> hw/rtl/rsl_sqrt.sv
`default_nettype none
module rsl_sqrt #(
    parameter int LUM_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire rsl_pkg::t_ctl               i_ctl,
    input  wire logic [rsl_pkg::DSQ_BITS-1:0] i_dsq,
    input  wire logic [LUM_BITS-1:0]         i_lum,
    output rsl_pkg::t_ctl                    o_ctl,
    output logic [rsl_pkg::ROOT_BITS-1:0]    o_root,
    output logic [LUM_BITS-1:0]              o_lum
);
    import rsl_pkg::*;

    t_sq                 r_sq   [SQ_STAGES];
    t_ctl                r_ctl  [SQ_STAGES];
    logic [LUM_BITS-1:0] r_lum  [SQ_STAGES];
    t_sq                 sq_in  [SQ_STAGES];
    t_ctl                ctl_in [SQ_STAGES];
    logic [LUM_BITS-1:0] lum_in [SQ_STAGES];

    // radicand is dsq with 16 fraction bits, root comes out with 8
    always_comb begin
        sq_in[0]  = '{rem: '0, root: '0, rad: {i_dsq, {(RAD_BITS-DSQ_BITS){1'b0}}}};
        ctl_in[0] = i_ctl;
        lum_in[0] = i_lum;
        for (int k = 1; k < SQ_STAGES; k++) begin
            sq_in[k]  = r_sq[k-1];
            ctl_in[k] = r_ctl[k-1];
            lum_in[k] = r_lum[k-1];
        end
    end

    // valid bits reset, data only moves
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SQ_STAGES; k++) begin
            if (!i_rst_n) begin
                r_ctl[k].vld <= 1'b0;
            end else if (i_en) begin
                r_ctl[k].vld <= ctl_in[k].vld;
            end
            if (i_en) begin
                r_sq[k]       <= sqrt_steps(sq_in[k]);
                r_ctl[k].zero <= ctl_in[k].zero;
                r_lum[k]      <= lum_in[k];
            end
        end
    end

    assign o_ctl  = r_ctl[SQ_STAGES-1];
    assign o_root = r_sq[SQ_STAGES-1].root;
    assign o_lum  = r_lum[SQ_STAGES-1];

endmodule
`default_nettype wire

>>> hw/rtl/rsl_scale.sv
`default_nettype none
module rsl_scale #(
    parameter int LUM_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire rsl_pkg::t_ctl                i_ctl,
    input  wire logic [rsl_pkg::ROOT_BITS-1:0] i_root,
    input  wire logic [LUM_BITS-1:0]          i_lum,
    output logic                              o_vld,
    output logic [LUM_BITS-1:0]               o_lum
);
    import rsl_pkg::*;

    logic [NUM_BITS-1:0]             num;
    logic [PROD_BITS-1:0]            r_prod;
    t_ctl                            r_ctl;
    logic [LUM_BITS-1:0]             r_lum_a;
    logic [ROOT_BITS-1:0]            quot;
    logic [FACTOR_BITS-1:0]          factor;
    logic [LUM_BITS+FACTOR_BITS-1:0] scaled;
    logic                            r_vld;
    logic [LUM_BITS-1:0]             r_lum;

    // 64*d8 + 25, then times the reciprocal of 50
    assign num = {i_root, 6'b0} + ROUND_ADD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r_ctl.vld <= i_ctl.vld;
        end
        if (i_en) begin
            r_prod     <= PROD_BITS'(num) * PROD_BITS'(RECIP_M);
            r_ctl.zero <= i_ctl.zero;
            r_lum_a    <= i_lum;
        end
    end

    assign quot   = r_prod[RECIP_SHIFT +: ROOT_BITS];
    assign factor = ONE_Q16 - {1'b0, quot};
    assign scaled = (LUM_BITS+FACTOR_BITS)'(r_lum_a) * (LUM_BITS+FACTOR_BITS)'(factor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= r_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lum <= r_ctl.zero ? '0 : scaled[16 +: LUM_BITS];
        end
    end

    assign o_vld = r_vld;
    assign o_lum = r_lum;

endmodule
`default_nettype wire

>>> hw/rtl/radial_spotlight_luminance_top.sv
// an accepted item passes the distance, square root and scale stages before its result reaches the output
// throughput: one item per cycle when not stalled; every stage is a register, the widest is a 22x23 multiply
// a stall on the output freezes the whole pipeline, so no item is lost or repeated
// reset is synchronous and active low: clears all valid bits and both center registers
// centers come back as 0; pready is always high
`default_nettype none
module radial_spotlight_luminance_top #(
    parameter int COORD_BITS = 12,
    parameter int LUM_BITS   = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // pixel input
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // pix_col, pix_row, lum_in from bit 0 up, zero padded to bytes
    input  wire logic [((2*COORD_BITS+LUM_BITS+7)/8)*8-1:0] i_s_tdata,
    // result output
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // lum_out from bit 0 up, zero padded to bytes
    output logic [((LUM_BITS+7)/8)*8-1:0]         o_m_tdata,
    // register port
    input  wire logic                             i_psel,
    input  wire logic                             i_penable,
    input  wire logic                             i_pwrite,
    input  wire logic [rsl_pkg::ADDR_BITS-1:0]    i_paddr,
    input  wire logic [rsl_pkg::DATA_BITS-1:0]    i_pwdata,
    output logic [rsl_pkg::DATA_BITS-1:0]         o_prdata,
    output logic                                  o_pready
);
    import rsl_pkg::*;

    localparam int OUT_W = ((LUM_BITS + 7) / 8) * 8;

    logic [CENTER_BITS-1:0] r_cx, r_cy;
    logic                   cfg_wr;
    t_reg_idx               reg_idx;
    logic                   en;

    logic [COORD_BITS-1:0]  pix_col, pix_row;
    logic [LUM_BITS-1:0]    lum_in;

    t_ctl                   dist_ctl, sqrt_ctl;
    logic [DSQ_BITS-1:0]    dist_dsq;
    logic [LUM_BITS-1:0]    dist_lum, sqrt_lum, lum_out;
    logic [ROOT_BITS-1:0]   sqrt_root;
    logic                   out_vld;

    // ---------------------------------------------------------------
    // register port: center_x at 0, center_y at 4, low address bits ignored
    // ---------------------------------------------------------------
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;
    assign reg_idx  = t_reg_idx'(i_paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_CENTER_X: r_cx <= i_pwdata[CENTER_BITS-1:0];
                REG_CENTER_Y: r_cy <= i_pwdata[CENTER_BITS-1:0];
                default: ;
            endcase
        end
    end

    // reads return the sign-extended center
    always_comb begin
        unique case (reg_idx)
            REG_CENTER_X: o_prdata = {{(DATA_BITS-CENTER_BITS){r_cx[CENTER_BITS-1]}}, r_cx};
            REG_CENTER_Y: o_prdata = {{(DATA_BITS-CENTER_BITS){r_cy[CENTER_BITS-1]}}, r_cy};
            default:      o_prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // flow control: the pipeline moves whenever the output register is
    // empty or being taken
    // ---------------------------------------------------------------
    assign en         = !out_vld || i_m_tready;
    assign o_s_tready = en;

    assign pix_col = i_s_tdata[0 +: COORD_BITS];
    assign pix_row = i_s_tdata[COORD_BITS +: COORD_BITS];
    assign lum_in  = i_s_tdata[2*COORD_BITS +: LUM_BITS];

    // offsets, squares, squared distance and the radius check (2 stages)
    rsl_dist #(
        .COORD_BITS (COORD_BITS),
        .LUM_BITS   (LUM_BITS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_col   (pix_col),
        .i_row   (pix_row),
        .i_lum   (lum_in),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .o_ctl   (dist_ctl),
        .o_dsq   (dist_dsq),
        .o_lum   (dist_lum)
    );

    // distance with 8 fraction bits, four root bits per stage (4 stages)
    rsl_sqrt #(
        .LUM_BITS (LUM_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (dist_ctl),
        .i_dsq   (dist_dsq),
        .i_lum   (dist_lum),
        .o_ctl   (sqrt_ctl),
        .o_root  (sqrt_root),
        .o_lum   (sqrt_lum)
    );

    // falloff factor and the luminance multiply (2 stages, last is the output register)
    rsl_scale #(
        .LUM_BITS (LUM_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (sqrt_ctl),
        .i_root  (sqrt_root),
        .i_lum   (sqrt_lum),
        .o_vld   (out_vld),
        .o_lum   (lum_out)
    );

    assign o_m_tvalid = out_vld;
    assign o_m_tdata  = OUT_W'(lum_out);

endmodule
`default_nettype wire

>>> hw/rtl/rsl_checker.sv
`default_nettype none
module rsl_checker #(
    parameter int COORD_BITS = 12,
    parameter int LUM_BITS   = 16
) (
    input wire logic                                   i_clk,
    input wire logic                                   i_rst_n,
    input wire logic                                   i_s_tvalid,
    input wire logic                                   o_s_tready,
    input wire logic [((2*COORD_BITS+LUM_BITS+7)/8)*8-1:0] i_s_tdata,
    input wire logic                                   o_m_tvalid,
    input wire logic                                   i_m_tready,
    input wire logic [((LUM_BITS+7)/8)*8-1:0]          o_m_tdata,
    input wire logic                                   i_psel,
    input wire logic                                   i_penable,
    input wire logic                                   i_pwrite,
    input wire logic [rsl_pkg::ADDR_BITS-1:0]          i_paddr,
    input wire logic [rsl_pkg::DATA_BITS-1:0]          i_pwdata,
    input wire logic [rsl_pkg::DATA_BITS-1:0]          o_prdata,
    input wire logic                                   o_pready
);
    import rsl_pkg::*;

    // nothing comes out in the cycle after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // a waiting input item stays put until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_s_tready |=> i_s_tvalid && $stable(i_s_tdata))
        else $error("waiting input item changed");

    // input is taken exactly when the pipeline can move
    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready out of step with output");

    // a written center reads back
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_psel && i_penable && i_pwrite && o_pready)
            && (i_paddr[2] == $past(i_paddr[2]))
        |-> o_prdata[CENTER_BITS-1:0] == $past(i_pwdata[CENTER_BITS-1:0]))
        else $error("center register readback mismatch");

endmodule

bind radial_spotlight_luminance_top rsl_checker #(
    .COORD_BITS (COORD_BITS),
    .LUM_BITS   (LUM_BITS)
) u_rsl_checker (.*);
`default_nettype wire

>>> tb/tb_radial_spotlight_luminance_top.sv
module tb_radial_spotlight_luminance_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS   = 12;
    localparam int LUM_BITS     = 16;
    localparam int IN_BITS      = ((2 * COORD_BITS + LUM_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = ((LUM_BITS + 7) / 8) * 8;
    localparam int SPOT_RADIUS  = 200;
    localparam int NUM_PHASES   = 6;
    localparam int RAND_PER_SET = 130;
    localparam int PIPE_SLACK   = 12;        // settling time after the last result is checked
    localparam int LIMIT_CYCLES = 200000;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int LUM_MAX      = (1 << LUM_BITS) - 1;

    // one pixel as it sits in tdata, col in the lowest bits
    typedef struct packed {
        logic [LUM_BITS-1:0]   lum;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
    } t_pix;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // pixel stream toward the block
    logic               s_valid = 1'b0;
    logic [IN_BITS-1:0] s_data  = '0;    // pix_col, pix_row, lum_in from bit 0 up
    wire logic          s_ready;

    // luminance stream out of the block
    wire logic                m_valid;
    logic                     m_ready = 1'b0;
    wire logic [OUT_BITS-1:0] m_data;  // lum_out from bit 0 up

    // register port
    logic                              psel    = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite  = 1'b0;
    logic [rsl_pkg::ADDR_BITS-1:0]     paddr   = '0;
    logic [rsl_pkg::DATA_BITS-1:0]     pwdata  = '0;
    wire logic [rsl_pkg::DATA_BITS-1:0] prdata;
    wire logic                         pready;

    radial_spotlight_luminance_top #(
        .COORD_BITS(COORD_BITS),
        .LUM_BITS  (LUM_BITS)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_valid),
        .o_s_tready(s_ready),
        .i_s_tdata (s_data),
        .o_m_tvalid(m_valid),
        .i_m_tready(m_ready),
        .o_m_tdata (m_data),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    always #4 clk = ~clk;

    // local copy of the spotlight center, follows every register write
    int spot_cx = 0;
    int spot_cy = 0;

    t_pix                pixel_queue[$];   // pixels waiting for the driver
    logic [LUM_BITS-1:0] lum_expect[$];    // predicted luminance, oldest first

    int  src_idle   = 0;   // percent of cycles the pixel side holds back
    int  dst_idle   = 0;   // percent of cycles the result side stalls
    bit  in_taken   = 1'b0;
    int  n_pushed   = 0;
    int  n_taken    = 0;
    int  n_checked  = 0;
    int  n_dark     = 0;   // pixels predicted to go fully dark
    int  n_lit      = 0;   // pixels inside the radius with nonzero luminance
    int  mismatches = 0;
    int  cycles     = 0;

    // luminance after the radial falloff around (ox, oy)
    function automatic logic [LUM_BITS-1:0] dimmed_lum(t_pix px, int ox, int oy);
        longint          dx;
        longint          dy;
        longint unsigned dsq;
        longint unsigned rad;
        longint unsigned root;
        longint unsigned probe;
        longint unsigned factor;
        dx  = longint'(px.col) - ox;
        dy  = longint'(px.row) - oy;
        dsq = dx * dx + dy * dy;
        if (dsq >= SPOT_RADIUS * SPOT_RADIUS) begin
            return '0;
        end
        // distance with 8 fraction bits by a bitwise integer root
        rad  = dsq << 16;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            probe = root | (64'd1 << b);
            if (probe * probe <= rad) begin
                root = probe;
            end
        end
        // 1 - 0.005*d in Q.16, rounded half up, then a truncating scale
        factor = 65536 - (64 * root + 25) / 50;
        return LUM_BITS'((px.lum * factor) >> 16);
    endfunction

    // pixel driver: holds an item until taken, idles at random between items
    always @(negedge clk) begin
        if (rst_n) begin
            if (!s_valid || in_taken) begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= src_idle) begin
                    s_data  <= pixel_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= dst_idle);
        end
    end

    // input side: every accepted pixel gets its prediction
    always @(posedge clk) begin
        in_taken = 1'b0;
        if (rst_n && s_valid && s_ready) begin
            in_taken = 1'b1;
            lum_expect.push_back(dimmed_lum(t_pix'(s_data), spot_cx, spot_cy));
            if (lum_expect[$] == '0) begin
                n_dark++;
            end else begin
                n_lit++;
            end
            n_taken++;
        end
    end

    // output side: compare against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            if (lum_expect.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: lum_out %0d with nothing pending",
                             m_data[LUM_BITS-1:0]);
                end
            end else begin
                if (m_data[LUM_BITS-1:0] !== lum_expect[0]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("lum_out mismatch at result %0d: expected %0d, got %0d",
                                 n_checked, lum_expect[0], m_data[LUM_BITS-1:0]);
                    end
                end
                void'(lum_expect.pop_front());
                n_checked++;
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycles, lum_expect.size());
            $display("Verification failed");
            $finish;
        end
    end

    // two-phase register write, setup then access
    task automatic write_center(rsl_pkg::t_reg_idx idx, int value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rsl_pkg::ADDR_BITS'(4 * int'(idx));
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == rsl_pkg::REG_CENTER_X) begin
            spot_cx = value;
        end else begin
            spot_cy = value;
        end
    endtask

    // read a center register back and check its 14 bits
    task automatic check_center(rsl_pkg::t_reg_idx idx);
        logic [rsl_pkg::DATA_BITS-1:0] rdata;
        int                            want;
        want = (idx == rsl_pkg::REG_CENTER_X) ? spot_cx : spot_cy;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= rsl_pkg::ADDR_BITS'(4 * int'(idx));
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rdata[rsl_pkg::CENTER_BITS-1:0] !== rsl_pkg::CENTER_BITS'(want)) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("register %s readback: expected %0d, got 0x%0h",
                         idx.name(), want, rdata);
            end
        end
    endtask

    task automatic push_pixel(int col, int row, int lum);
        t_pix px;
        px.col = COORD_BITS'(col);
        px.row = COORD_BITS'(row);
        px.lum = LUM_BITS'(lum);
        pixel_queue.push_back(px);
        n_pushed++;
    endtask

    // let every queued pixel through and the pipeline settle
    task automatic wait_idle();
        do @(negedge clk); while (n_taken != n_pushed || lum_expect.size() != 0);
        repeat (PIPE_SLACK) @(negedge clk);
    endtask

    // pixel mostly near the center so the falloff gets exercised
    task automatic push_random_pixel();
        int col;
        int row;
        int lum;
        col = spot_cx + int'($urandom_range(0, 2 * SPOT_RADIUS + 40)) - SPOT_RADIUS - 20;
        row = spot_cy + int'($urandom_range(0, 2 * SPOT_RADIUS + 40)) - SPOT_RADIUS - 20;
        if ($urandom_range(99) < 20 || col < 0 || col > COORD_MAX) begin
            col = $urandom_range(0, COORD_MAX);
        end
        if ($urandom_range(99) < 20 || row < 0 || row > COORD_MAX) begin
            row = $urandom_range(0, COORD_MAX);
        end
        case ($urandom_range(0, 9))
            0:       lum = 0;
            1:       lum = LUM_MAX;
            default: lum = $urandom_range(0, LUM_MAX);
        endcase
        push_pixel(col, row, lum);
    endtask

    int set_cx[NUM_PHASES];
    int set_cy[NUM_PHASES];

    initial begin
        // centers: near the corner, both extremes, inside, partly outside, random
        set_cx = '{100, -4096, 8191, 2048, -150, 0};
        set_cy = '{100, 8191, -4096, 3000, 4200, 0};
        set_cx[NUM_PHASES-1] = int'($urandom_range(0, 12287)) - 4096;
        set_cy[NUM_PHASES-1] = int'($urandom_range(0, 12287)) - 4096;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // centers come out of reset at zero
        check_center(rsl_pkg::REG_CENTER_X);
        check_center(rsl_pkg::REG_CENTER_Y);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // pixel side stalls lightly and the sink heavily, then swapped, then none
            case (p / 2)
                0: begin
                    src_idle = 22;
                    dst_idle = 86;
                end
                1: begin
                    src_idle = 86;
                    dst_idle = 22;
                end
                default: begin
                    src_idle = 0;
                    dst_idle = 0;
                end
            endcase
            write_center(rsl_pkg::REG_CENTER_X, set_cx[p]);
            write_center(rsl_pkg::REG_CENTER_Y, set_cy[p]);
            check_center(rsl_pkg::REG_CENTER_X);
            check_center(rsl_pkg::REG_CENTER_Y);

            if (p == 0) begin
                // center at (100,100)
                push_pixel(100, 100, LUM_MAX);        // distance zero passes unchanged
                push_pixel(100, 100, 0);
                push_pixel(100, 100, 1);
                push_pixel(101, 100, LUM_MAX);        // one pixel off center
                push_pixel(100, 99, 16'h8000);
                push_pixel(300, 100, LUM_MAX);        // exactly on the radius
                push_pixel(100, 300, LUM_MAX);
                push_pixel(299, 119, LUM_MAX);        // just inside the radius
                push_pixel(299, 120, LUM_MAX);        // just outside
                push_pixel(0, 0, LUM_MAX);            // image corner, top left
                push_pixel(0, 0, 16'h5555);
                push_pixel(COORD_MAX, COORD_MAX, LUM_MAX);  // far corner
                push_pixel(COORD_MAX, 0, 16'hAAAA);
                push_pixel(0, COORD_MAX, LUM_MAX);
                push_pixel(12'hAAA, 12'h555, 16'hFFFF);
                push_pixel(12'h555, 12'hAAA, 16'h0001);
                push_pixel(241, 241, LUM_MAX);        // on the diagonal just inside
                push_pixel(242, 242, LUM_MAX);        // on the diagonal just outside
                push_pixel(150, 60, 16'h7FFF);
                push_pixel(1, 199, 16'hFFFE);
            end
            for (int i = 0; i < RAND_PER_SET; i++) begin
                push_random_pixel();
            end
            wait_idle();
        end

        $display("checked %0d pixels over %0d center settings plus the reset value,",
                 n_checked, NUM_PHASES);
        $display("%0d inside the spotlight, %0d dark, centers from -4096 to 8191",
                 n_lit, n_dark);
        if (mismatches == 0 && lum_expect.size() == 0 && n_checked == n_pushed) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/rsl_pkg.sv
hw/rtl/rsl_dist.sv
hw/rtl/rsl_sqrt.sv
hw/rtl/rsl_scale.sv
hw/rtl/radial_spotlight_luminance_top.sv
hw/rtl/rsl_checker.sv
tb/tb_radial_spotlight_luminance_top.sv
